[rtl/core/sspq_pkg.sv]
// sspq_pkg: shared types and codes for the stable sorted priority queue
// no dependencies; imported by the cell and the top level

package sspq_pkg;

  // operation codes carried in the kind field of an input item
  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  // per-cycle command broadcast from the top level to every cell
  typedef struct packed {
    logic push;  // accepted push that fits
    logic pop;   // accepted pop of a stored entry
  } cell_ctrl_t;

endpackage : sspq_pkg

[rtl/core/sspq_in_if.sv]
// sspq_in_if: input channel of the priority queue, valid/ready plus item fields
// no dependencies

interface sspq_in_if #(
  parameter int PRIORITY_BITS = 16,
  parameter int PAYLOAD_BITS  = 32
);
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [PRIORITY_BITS-1:0] priority_req;
  logic [PAYLOAD_BITS-1:0]  payload;

  modport source (output valid, output kind, output priority_req, output payload,
                  input ready);
  modport sink   (input valid, input kind, input priority_req, input payload,
                  output ready);
endinterface : sspq_in_if

[rtl/core/sspq_out_if.sv]
// sspq_out_if: result channel of the priority queue, valid/ready plus item fields
// no dependencies

interface sspq_out_if #(
  parameter int PRIORITY_BITS = 16,
  parameter int PAYLOAD_BITS  = 32
);
  logic                     valid;
  logic                     ready;
  logic                     out_valid;
  logic [PRIORITY_BITS-1:0] out_priority;
  logic [PAYLOAD_BITS-1:0]  out_payload;
  logic                     rejected;
  logic                     now_empty;
  logic                     now_full;

  modport source (output valid, output out_valid, output out_priority,
                  output out_payload, output rejected, output now_empty,
                  output now_full, input ready);
  modport sink   (input valid, input out_valid, input out_priority,
                  input out_payload, input rejected, input now_empty,
                  input now_full, output ready);
endinterface : sspq_out_if

[rtl/core/sspq_cell.sv]
// sspq_cell: one slot of the sorted chain, holds an entry and an occupied flag
// depends on sspq_pkg (cell_ctrl_t)

module sspq_cell
  import sspq_pkg::*;
#(
  parameter int PRIORITY_BITS = 16,
  parameter int PAYLOAD_BITS  = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_ctrl_t               ctrl,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [PAYLOAD_BITS-1:0]  new_pay,
  input  logic                     left_occ,
  input  logic                     left_gt,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [PAYLOAD_BITS-1:0]  left_pay,
  input  logic                     right_occ,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  logic [PAYLOAD_BITS-1:0]  right_pay,
  output logic                     occ,
  output logic                     gt,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic [PAYLOAD_BITS-1:0]  pay
);

  logic                     occ_r, occ_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic [PAYLOAD_BITS-1:0]  pay_r, pay_nxt;

  // free slot or strictly larger priority: new entry goes at or before here
  assign gt = !occ_r || (prio_r > new_prio);

  always_comb begin
    occ_nxt  = occ_r;
    prio_nxt = prio_r;
    pay_nxt  = pay_r;
    if (ctrl.push) begin
      if (left_gt) begin
        occ_nxt  = left_occ;
        prio_nxt = left_prio;
        pay_nxt  = left_pay;
      end else if (gt) begin
        occ_nxt  = 1'b1;
        prio_nxt = new_prio;
        pay_nxt  = new_pay;
      end
    end else if (ctrl.pop) begin
      occ_nxt  = right_occ;
      prio_nxt = right_prio;
      pay_nxt  = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    pay_r  <= pay_nxt;
  end

  assign occ  = occ_r;
  assign prio = prio_r;
  assign pay  = pay_r;

endmodule : sspq_cell

[rtl/core/stable_sorted_priority_queue_core.sv]
// stable_sorted_priority_queue_core: top level of the min-first sorted queue
// depends on sspq_pkg, sspq_in_if, sspq_out_if and sspq_cell

// Min-first priority queue built as a chain of CAPACITY cells, slot 0 at the
// front. Every cell compares the pushed priority with its own in parallel, so
// a push lands behind all entries of lower or equal priority (equal priorities
// leave in arrival order) and a pop shifts the chain one slot forward. Each
// input item gives exactly one result item. The chain updates at the edge that
// accepts an item and the result sits in an output register from the next cycle,
// so one item per cycle is sustained while the result side takes items; the
// single per-cell compare sets that figure.
// A push into a full queue is dropped and flagged as rejected, a pop of an
// empty queue returns zeros with out_valid low. Every result also reports
// whether the queue is empty and full after the item. No clearing pass:
// the queue is empty straight out of reset.

module stable_sorted_priority_queue_core
  import sspq_pkg::*;
#(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 16,
  parameter int PAYLOAD_BITS  = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  sspq_in_if.sink    in_ch,
  sspq_out_if.source out_ch
);

  // chain state as seen on the cell outputs
  logic [CAPACITY-1:0]      occ_w;
  logic [CAPACITY-1:0]      gt_w;
  logic [PRIORITY_BITS-1:0] prio_w [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  pay_w  [CAPACITY];

  logic       in_acc;
  logic       is_pop;
  logic       empty_now;
  logic       full_now;
  cell_ctrl_t ctrl;

  // result register
  logic                     vld_r,   vld_nxt;
  logic                     ov_r,    ov_nxt;
  logic [PRIORITY_BITS-1:0] oprio_r, oprio_nxt;
  logic [PAYLOAD_BITS-1:0]  opay_r,  opay_nxt;
  logic                     rej_r,   rej_nxt;
  logic                     emp_r,   emp_nxt;
  logic                     ful_r,   ful_nxt;

  // take a new item whenever the result register is free or being drained
  assign in_ch.ready = !vld_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_pop      = (in_ch.kind == KIND_POP);

  // occupancy is a thermometer code from the front
  assign empty_now = !occ_w[0];
  assign full_now  = occ_w[CAPACITY-1];

  assign ctrl.push = in_acc && !is_pop && !full_now;
  assign ctrl.pop  = in_acc && is_pop && !empty_now;

  // row of cells, each wired to its neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     l_occ, l_gt, r_occ;
    logic [PRIORITY_BITS-1:0] l_prio, r_prio;
    logic [PAYLOAD_BITS-1:0]  l_pay,  r_pay;

    if (i == 0) begin : g_front
      assign l_occ  = 1'b0;
      assign l_gt   = 1'b0;
      assign l_prio = '0;
      assign l_pay  = '0;
    end else begin : g_mid_l
      assign l_occ  = occ_w[i-1];
      assign l_gt   = gt_w[i-1];
      assign l_prio = prio_w[i-1];
      assign l_pay  = pay_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign r_occ  = 1'b0;
      assign r_prio = '0;
      assign r_pay  = '0;
    end else begin : g_mid_r
      assign r_occ  = occ_w[i+1];
      assign r_prio = prio_w[i+1];
      assign r_pay  = pay_w[i+1];
    end

    sspq_cell #(
      .PRIORITY_BITS (PRIORITY_BITS),
      .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_prio   (in_ch.priority_req),
      .new_pay    (in_ch.payload),
      .left_occ   (l_occ),
      .left_gt    (l_gt),
      .left_prio  (l_prio),
      .left_pay   (l_pay),
      .right_occ  (r_occ),
      .right_prio (r_prio),
      .right_pay  (r_pay),
      .occ        (occ_w[i]),
      .gt         (gt_w[i]),
      .prio       (prio_w[i]),
      .pay        (pay_w[i])
    );
  end

  // build the result of the accepted item
  always_comb begin
    vld_nxt   = vld_r;
    ov_nxt    = ov_r;
    oprio_nxt = oprio_r;
    opay_nxt  = opay_r;
    rej_nxt   = rej_r;
    emp_nxt   = emp_r;
    ful_nxt   = ful_r;
    if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
    if (in_acc) begin
      vld_nxt   = 1'b1;
      ov_nxt    = ctrl.pop;
      oprio_nxt = ctrl.pop ? prio_w[0] : '0;
      opay_nxt  = ctrl.pop ? pay_w[0] : '0;
      rej_nxt   = !is_pop && full_now;
      // flags after the item
      if (ctrl.push) begin
        emp_nxt = 1'b0;
        ful_nxt = occ_w[CAPACITY-2];
      end else if (ctrl.pop) begin
        emp_nxt = !occ_w[1];
        ful_nxt = 1'b0;
      end else begin
        emp_nxt = empty_now;
        ful_nxt = full_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ov_r    <= ov_nxt;
    oprio_r <= oprio_nxt;
    opay_r  <= opay_nxt;
    rej_r   <= rej_nxt;
    emp_r   <= emp_nxt;
    ful_r   <= ful_nxt;
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.out_valid    = ov_r;
  assign out_ch.out_priority = oprio_r;
  assign out_ch.out_payload  = opay_r;
  assign out_ch.rejected     = rej_r;
  assign out_ch.now_empty    = emp_r;
  assign out_ch.now_full     = ful_r;

`ifndef SYNTH
  // occupied slots always form a contiguous run from the front
  a_thermo : assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_w + CAPACITY'(1)) & occ_w) == '0)
    else $error("occupancy not contiguous");

  // the two front entries stay in priority order
  a_sorted : assert property (@(posedge clk) disable iff (!rst_n)
    occ_w[1] |-> (prio_w[0] <= prio_w[1]))
    else $error("front entries out of order");

  // a push into a full queue is reported as rejected and leaves it full
  a_reject : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_pop && full_now) |=> (out_ch.rejected && full_now))
    else $error("full push not rejected");

  // a pop of a stored entry returns the old front
  a_pop : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |=> (out_ch.out_valid && out_ch.out_priority == $past(prio_w[0])))
    else $error("pop returned wrong entry");

  // reported flags match the chain after the item
  a_flags : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_ch.now_empty == empty_now && out_ch.now_full == full_now))
    else $error("status flags disagree with chain");
`endif

endmodule : stable_sorted_priority_queue_core

[sim/tb.sv]
// tb: self-checking bench for the stable sorted priority queue core, driven over
// valid/ready channels with random idling on both sides and a scoreboard in step
// depends on sspq_pkg, sspq_in_if, sspq_out_if and stable_sorted_priority_queue_core

import sspq_pkg::*;

typedef struct packed {
  logic [15:0] prio;
  logic [31:0] tag;
} entry_t;

typedef struct packed {
  logic        popped;
  logic [15:0] prio;
  logic [31:0] tag;
  logic        rejected;
  logic        empty;
  logic        full;
} result_t;

class pq_scoreboard;
  int unsigned depth;
  entry_t      held[$];  // sorted store, front first
  result_t     due[$];   // results still owed by the block
  int unsigned mismatches;
  int unsigned pushes, rejects, pops, dry_pops, deepest;

  function new(int unsigned cap);
    depth = cap;
  endfunction

  // works out the result of an accepted item and moves the sorted store on
  function void note_item(kind_t kind, logic [15:0] prio, logic [31:0] tag);
    result_t r;
    entry_t  e;
    int      pos;
    r = '0;
    if (kind == KIND_PUSH) begin
      pushes++;
      if (held.size() >= depth) begin
        r.rejected = 1'b1;
        rejects++;
      end else begin
        // stable insert: behind every entry of lower or equal priority
        pos = held.size();
        for (int i = 0; i < held.size(); i++) begin
          if (held[i].prio > prio) begin
            pos = i;
            break;
          end
        end
        e.prio = prio;
        e.tag  = tag;
        held.insert(pos, e);
      end
    end else begin
      pops++;
      if (held.size() == 0) begin
        dry_pops++;
      end else begin
        r.popped = 1'b1;
        r.prio   = held[0].prio;
        r.tag    = held[0].tag;
        held.delete(0);
      end
    end
    r.empty = (held.size() == 0);
    r.full  = (held.size() == depth);
    if (held.size() > deepest) deepest = held.size();
    due.push_back(r);
  endfunction

  function void check_result(result_t got);
    result_t want;
    bit      bad;
    if (due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: result with nothing outstanding, popped=%0b prio=%0d tag=%h",
                 got.popped, got.prio, got.tag);
      return;
    end
    want = due.pop_front();
    bad = (got.popped !== want.popped) || (got.prio !== want.prio) ||
          (got.tag !== want.tag) || (got.rejected !== want.rejected) ||
          (got.empty !== want.empty) || (got.full !== want.full);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: exp popped=%0b prio=%0d tag=%h rejected=%0b empty=%0b full=%0b",
                 want.popped, want.prio, want.tag, want.rejected, want.empty, want.full);
        $display("          got popped=%0b prio=%0d tag=%h rejected=%0b empty=%0b full=%0b",
                 got.popped, got.prio, got.tag, got.rejected, got.empty, got.full);
      end
    end
  endfunction
endclass

module tb;
  localparam int CAPACITY    = 16;
  localparam int IDLE_LIMIT  = 1000;
  localparam int TOTAL_ITEMS = 950;
  localparam int CALM_ITEMS  = 150;

  // traffic mix of one random phase
  typedef enum int {
    MIX_FILLING,
    MIX_DRAINING,
    MIX_BALANCED
  } mix_t;

  logic         clk;
  logic         rst_n;
  bit           calm;       // last stretch: no idling anywhere
  bit           idling_on;  // current phase allows idle bursts
  int unsigned  sent;
  pq_scoreboard sb;

  sspq_in_if  #(.PRIORITY_BITS(16), .PAYLOAD_BITS(32)) in_ch ();
  sspq_out_if #(.PRIORITY_BITS(16), .PAYLOAD_BITS(32)) out_ch ();

  stable_sorted_priority_queue_core #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (16),
    .PAYLOAD_BITS  (32)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // offer one item from the falling edge and hold it until taken
  task automatic send_item(kind_t kind, logic [15:0] prio, logic [31:0] tag);
    if (!calm && idling_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.priority_req <= prio;
    in_ch.payload      <= tag;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_item(kind, prio, tag);
    sent++;
  endtask

  // stop offering and wait for every owed result
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  // result side: ready low in random bursts
  initial begin : result_side
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!calm && idling_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(result_t'{out_ch.out_valid, out_ch.out_priority, out_ch.out_payload,
                                out_ch.rejected, out_ch.now_empty, out_ch.now_full});
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    mix_t        mode;
    int          phase_len;
    int          pop_pct;
    kind_t       k;
    logic [15:0] p;
    logic [31:0] t;
    sb                 = new(CAPACITY);
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_PUSH;
    in_ch.priority_req = '0;
    in_ch.payload      = '0;
    rst_n              = 1'b0;
    calm               = 1'b0;
    idling_on          = 1'b1;
    sent               = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, field extremes, ties, fill, refused push
    send_item(KIND_POP, 16'd0, 32'd0);
    send_item(KIND_PUSH, 16'hffff, 32'hffff_ffff);
    send_item(KIND_PUSH, 16'h0000, 32'h0000_0000);
    send_item(KIND_PUSH, 16'd7, 32'd1);  // equal priorities leave in arrival order
    send_item(KIND_PUSH, 16'd7, 32'd2);
    send_item(KIND_PUSH, 16'd7, 32'd3);
    repeat (11) send_item(KIND_PUSH, 16'($urandom_range(0, 15)), $urandom);
    send_item(KIND_PUSH, 16'd1, 32'hdead_beef);     // full, refused
    send_item(KIND_POP, 16'hffff, 32'hffff_ffff);   // fields of a pop are ignored
    send_item(KIND_PUSH, 16'd7, 32'd4);             // back to full by a push
    wait_drained();

    // random phases of filling, draining and mixed traffic
    while (sent < TOTAL_ITEMS) begin
      mode      = mix_t'($urandom_range(0, 2));
      idling_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(8, 40);
      if ($urandom_range(0, 7) == 0) wait_drained();
      case (mode)
        MIX_FILLING:  pop_pct = 15;
        MIX_DRAINING: pop_pct = 85;
        default:      pop_pct = 45;
      endcase
      repeat (phase_len) begin
        calm = (sent >= TOTAL_ITEMS - CALM_ITEMS);
        k = ($urandom_range(0, 99) < pop_pct) ? KIND_POP : KIND_PUSH;
        case ($urandom_range(0, 9))
          0:       p = 16'h0000;
          1:       p = 16'hffff;
          2, 3, 4: p = 16'($urandom_range(0, 65535));
          default: p = 16'($urandom_range(0, 7));  // dense range for ties
        endcase
        case ($urandom_range(0, 15))
          0:       t = 32'h0000_0000;
          1:       t = 32'hffff_ffff;
          default: t = $urandom;
        endcase
        send_item(k, p, t);
      end
    end

    calm = 1'b1;
    wait_drained();
    repeat (4) @(posedge clk);
    $display("run: %0d items, %0d pushes with %0d refused when full, %0d pops with %0d on empty",
             sent, sb.pushes, sb.rejects, sb.pops, sb.dry_pops);
    $display("run: deepest fill %0d of %0d, %0d mismatches", sb.deepest, CAPACITY,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/sspq_pkg.sv
rtl/core/sspq_in_if.sv
rtl/core/sspq_out_if.sv
rtl/core/sspq_cell.sv
rtl/core/stable_sorted_priority_queue_core.sv
sim/tb.sv
